### src/rpm_pkg.sv
// rpm_pkg: shared types, codes and constants for the relative pointer merger.
// No dependencies; imported by rpm_front, rpm_queue, rpm_back and the top level.
package rpm_pkg;

    localparam int SPEED_W     = 10;
    localparam int DELTA_W     = 16;
    localparam int POS_W       = 15;
    localparam int BTN_W       = 2;
    localparam int SRCIDX_W    = 2;
    localparam int MODE_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 1;

    // delta * speed: 16b signed x 11b signed, the value itself fits 26 bits
    localparam int MUL_W  = DELTA_W + SPEED_W + 1;
    localparam int PROD_W = 26;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(32);
    localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(512);
    localparam logic [POS_W-1:0]   POS_MAX     = POS_W'(32767);
    localparam logic [POS_W-1:0]   POS_RESET   = POS_W'(16383);

    localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [1:0] {
        OP_ARRIVE,
        OP_MOVE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [SRCIDX_W-1:0]        src;
        logic                       nonzero;
        logic signed [PROD_W-1:0]   prod_x;
        logic signed [PROD_W-1:0]   prod_y;
        logic [BTN_W-1:0]           btn;
    } t_entry;

    typedef struct packed {
        logic                 any_present;
        logic                 moved_flag;
        logic [BTN_W-1:0]     merged_buttons;
        logic [POS_W-1:0]     pos_y;
        logic [POS_W-1:0]     pos_x;
    } t_reply;

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(SUM_W-POS_W){1'b0}}, POS_MAX})) begin
            r = POS_MAX;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/relative_pointer_merger.sv
// relative_pointer_merger: top level that merges relative pointing sources into
// one clamped absolute position. Depends on rpm_pkg, rpm_front, rpm_queue, rpm_back.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: delta_x, delta_y, button_bits
//                                                tuser: mode, source
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: pos_x, pos_y, merged_buttons,
//                                                moved_flag, any_present; tuser: kind
//  cfg       in   i_cfg_wr_en (no wait)          i_cfg_wr_data: speed
//
// One beat per cycle sustained while the queue is not full. The front scales
// the deltas by speed in the accept cycle, the beat sits in a two-entry queue,
// and the back applies it to the position (add and clamp) and button state
// as it leaves the queue. Reset is synchronous, active low, and needs no
// clearing pass. s_axis_tready drops only while the queue is full, i.e. after
// the result register has been stalled by m_axis_tready; beats that give no
// result keep draining during such a stall.
module relative_pointer_merger #(
    parameter int SOURCES = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // speed register write; zero ignored, above 512 saturates
    input  logic                               i_cfg_wr_en,
    input  logic [rpm_pkg::SPEED_W-1:0]        i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] delta_x, [31:16] delta_y, [33:32] button_bits
    input  logic [rpm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] mode, [3:2] source
    input  logic [rpm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [14:0] pos_x, [29:15] pos_y, [31:30] merged_buttons, [32] moved_flag,
    // [33] any_present, [39:34] zero
    output logic [rpm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // [0] kind
    output logic [rpm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import rpm_pkg::*;

    // front -> queue
    logic   q_push;
    logic   q_full;
    t_entry q_in;
    // queue -> back
    logic   q_valid;
    logic   q_pop;
    t_entry q_out;

    rpm_front #(
        .SOURCES (SOURCES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_entry       (q_in)
    );

    // decouples intake from result stalls
    rpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_out)
    );

    rpm_back #(
        .SOURCES (SOURCES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_entry       (q_out),
        .o_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### src/rpm_front.sv
// rpm_front: input beat intake, classification, speed register and delta scaling.
// Depends on rpm_pkg; feeds rpm_queue.
module rpm_front #(
    parameter int SOURCES = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [rpm_pkg::SPEED_W-1:0]        i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rpm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic [rpm_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  logic                               i_q_full,
    output logic                               o_push,
    output rpm_pkg::t_entry                    o_entry
);
    import rpm_pkg::*;

    logic [SPEED_W-1:0]        r_speed;
    logic [MODE_W-1:0]         mode;
    logic [SRCIDX_W-1:0]       src;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [MUL_W-1:0]   mul_x;
    logic signed [MUL_W-1:0]   mul_y;
    logic                      src_ok;
    logic                      keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RESET;
        end else if (i_cfg_wr_en && (i_cfg_wr_data != '0)) begin
            r_speed <= (i_cfg_wr_data > SPEED_MAX) ? SPEED_MAX : i_cfg_wr_data;
        end
    end

    assign mode = s_axis_tuser[MODE_W-1:0];
    assign src  = s_axis_tuser[MODE_W +: SRCIDX_W];
    assign dx   = s_axis_tdata[DELTA_W-1:0];
    assign dy   = s_axis_tdata[DELTA_W +: DELTA_W];

    assign mul_x = dx * $signed({1'b0, r_speed});
    assign mul_y = dy * $signed({1'b0, r_speed});

    assign src_ok = (32'(src) < SOURCES);

    always_comb begin
        o_entry.src     = src;
        o_entry.nonzero = (dx != '0) || (dy != '0);
        o_entry.prod_x  = mul_x[PROD_W-1:0];
        o_entry.prod_y  = mul_y[PROD_W-1:0];
        o_entry.btn     = s_axis_tdata[2*DELTA_W +: BTN_W];
        o_entry.op      = OP_READ;
        keep            = 1'b0;
        unique case (mode)
            MODE_ARRIVE: begin
                o_entry.op = OP_ARRIVE;
                keep       = src_ok;
            end
            MODE_MOVE: begin
                o_entry.op = OP_MOVE;
                keep       = src_ok;
            end
            MODE_READ: begin
                o_entry.op = OP_READ;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // ignored beats are taken and dropped here
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && s_axis_tready && keep;

endmodule

### src/rpm_queue.sv
// rpm_queue: two-entry queue of classified operations between front and back.
// Depends on rpm_pkg.
module rpm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rpm_pkg::t_entry  i_entry,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output rpm_pkg::t_entry  o_entry
);
    import rpm_pkg::*;

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_CNT_W-1:0]   n_count;
    logic                 do_pop;

    assign do_pop = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (do_pop && !i_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

endmodule

### src/rpm_back.sv
// rpm_back: applies queued operations to position, button and presence state
// and drives the result register. Depends on rpm_pkg.
module rpm_back #(
    parameter int SOURCES = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  rpm_pkg::t_entry                    i_entry,
    output logic                               o_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rpm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [rpm_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import rpm_pkg::*;

    localparam int SRC_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;

    logic [POS_W-1:0]  r_pos_x;
    logic [POS_W-1:0]  r_pos_y;
    logic [BTN_W-1:0]  r_held [SOURCES];
    logic [SOURCES-1:0] r_present;
    logic              r_changed;
    logic              r_out_valid;
    logic              r_out_kind;
    t_reply            r_out;

    logic [SRC_W-1:0]        sidx;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [POS_W-1:0]        n_pos_x;
    logic [POS_W-1:0]        n_pos_y;
    logic                    btn_edge;
    logic [BTN_W-1:0]        merged_new;
    logic [BTN_W-1:0]        merged_now;
    logic                    any;
    logic                    emit;
    logic                    out_free;
    logic                    go;

    assign sidx = i_entry.src[SRC_W-1:0];

    assign sum_x = $signed({{(SUM_W-POS_W){1'b0}}, r_pos_x})
                 + $signed({i_entry.prod_x[PROD_W-1], i_entry.prod_x});
    assign sum_y = $signed({{(SUM_W-POS_W){1'b0}}, r_pos_y})
                 + $signed({i_entry.prod_y[PROD_W-1], i_entry.prod_y});

    assign n_pos_x = i_entry.nonzero ? clamp_pos(sum_x) : r_pos_x;
    assign n_pos_y = i_entry.nonzero ? clamp_pos(sum_y) : r_pos_y;

    assign btn_edge = (i_entry.op == OP_MOVE) && (i_entry.btn != r_held[sidx]);

    always_comb begin
        merged_new = '0;
        merged_now = '0;
        for (int i = 0; i < SOURCES; i++) begin
            merged_now = merged_now | r_held[i];
            merged_new = merged_new
                       | ((SRC_W'(i) == sidx) ? i_entry.btn : r_held[i]);
        end
    end

    assign any      = |r_present;
    assign emit     = (i_entry.op == OP_READ) || btn_edge;
    assign out_free = !r_out_valid || m_axis_tready;
    assign go       = i_q_valid && (out_free || !emit);
    assign o_pop    = go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= POS_RESET;
            r_pos_y     <= POS_RESET;
            r_present   <= '0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SOURCES; i++) begin
                r_held[i] <= '0;
            end
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (go) begin
                unique case (i_entry.op)
                    OP_ARRIVE: begin
                        r_present[sidx] <= 1'b1;
                    end
                    OP_MOVE: begin
                        r_present[sidx] <= 1'b1;
                        r_pos_x         <= n_pos_x;
                        r_pos_y         <= n_pos_y;
                        if (i_entry.nonzero || btn_edge) begin
                            r_changed <= 1'b1;
                        end
                        if (btn_edge) begin
                            r_held[sidx]         <= i_entry.btn;
                            r_out_valid          <= 1'b1;
                            r_out_kind           <= KIND_EDGE;
                            r_out.pos_x          <= n_pos_x;
                            r_out.pos_y          <= n_pos_y;
                            r_out.merged_buttons <= merged_new;
                            r_out.moved_flag     <= 1'b1;
                            r_out.any_present    <= 1'b1;
                        end
                    end
                    OP_READ: begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_READ;
                        if (any) begin
                            r_out.pos_x          <= r_pos_x;
                            r_out.pos_y          <= r_pos_y;
                            r_out.merged_buttons <= merged_now;
                            r_out.moved_flag     <= r_changed;
                            r_out.any_present    <= 1'b1;
                            r_changed            <= 1'b0;
                        end else begin
                            r_out <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_reply)){1'b0}}, r_out};

`ifndef SYNTH
    a_read_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_READ && !r_out.any_present)
        |-> (r_out.pos_x == '0 && r_out.pos_y == '0
             && r_out.merged_buttons == '0 && !r_out.moved_flag))
        else $error("read reply without source carries nonzero fields");

    a_edge_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_EDGE)
        |-> (r_out.moved_flag && r_out.any_present && r_changed))
        else $error("button edge beat without moved/present flags");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && i_entry.op == OP_READ && any) |=> !r_changed)
        else $error("moved flag not cleared by read");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> ($stable(r_out) && r_out_valid))
        else $error("pending result overwritten");
`endif

endmodule
